// File: rtl/core/hpt_pkg.sv
// Shared types, register indexes and helpers for the compensation core.
// Depends on nothing; hpt_front, hpt_back and the top level refer to it by scoped names.
package hpt_pkg;

  // Configuration register indexes
  localparam logic [2:0] CfgBytes0To7   = 3'd0;
  localparam logic [2:0] CfgBytes8To15  = 3'd1;
  localparam logic [2:0] CfgBytes16To23 = 3'd2;
  localparam logic [2:0] CfgHumFirst    = 3'd3;
  localparam logic [2:0] CfgBytes26To32 = 3'd4;

  // One raw sample
  typedef struct packed {
    logic [19:0] raw_t;
    logic [19:0] raw_p;
    logic [15:0] raw_h;
  } sample_t;

  // Unpacked calibration coefficients
  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
    logic        [7:0]  h1;
    logic signed [15:0] h2;
    logic        [7:0]  h3;
    logic signed [11:0] h4;
    logic signed [11:0] h5;
    logic signed [7:0]  h6;
  } cal_t;

  // Unpack the coefficients from the raw calibration bytes
  function automatic cal_t unpack_cal(logic [63:0] c0, logic [63:0] c1, logic [63:0] c2,
                                      logic [7:0] c3, logic [55:0] c4);
    cal_t c;
    c.t1 = c0[15:0];
    c.t2 = c0[31:16];
    c.t3 = c0[47:32];
    c.p1 = c0[63:48];
    c.p2 = c1[15:0];
    c.p3 = c1[31:16];
    c.p4 = c1[47:32];
    c.p5 = c1[63:48];
    c.p6 = c2[15:0];
    c.p7 = c2[31:16];
    c.p8 = c2[47:32];
    c.p9 = c2[63:48];
    c.h1 = c3;
    c.h2 = c4[15:0];
    c.h3 = c4[23:16];
    // byte 29 high, low nibble of byte 30
    c.h4 = {c4[31:24], c4[35:32]};
    // byte 31 high, high nibble of byte 30
    c.h5 = {c4[47:40], c4[39:36]};
    c.h6 = c4[55:48];
    return c;
  endfunction

  // Sign-extend the low 32 bits (32-bit wrap)
  function automatic logic [63:0] w32(logic [63:0] x);
    return {{32{x[31]}}, x[31:0]};
  endfunction

  // Signed divide by 2^k, truncating toward zero
  function automatic logic [63:0] sdiv_p2(logic [63:0] x, int unsigned k);
    logic        [63:0] bias;
    logic signed [63:0] s;
    bias = x[63] ? ((64'd1 << k) - 64'd1) : 64'd0;
    s    = signed'(x + bias);
    return 64'(s >>> k);
  endfunction

endpackage

// File: rtl/core/hpt_front.sv
// Front part: accepts raw samples into a two-beat queue.
// Depends on hpt_pkg for the sample type.
module hpt_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  hpt_pkg::sample_t in_data_i,
  output logic             q_valid_o,
  input  logic             q_take_i,
  output hpt_pkg::sample_t q_data_o
);

  hpt_pkg::sample_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i & ~in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_take_i & q_valid_o;
  assign q_data_o   = mem_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store incoming beat
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

endmodule

// File: rtl/core/hpt_divider.sv
// Iterative signed 64-bit divider, one quotient bit per cycle, truncating.
// Standalone; used by hpt_back for the pressure quotient.
module hpt_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic        done_o,
  output logic [63:0] quo_o
);

  logic [64:0] rem_q, rem_d;
  logic [63:0] quo_q, quo_d;
  logic [63:0] den_q, den_d;
  logic        neg_q, neg_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [64:0] shl;
  logic [64:0] diff;

  assign shl    = {rem_q[63:0], quo_q[63]};
  assign diff   = shl - {1'b0, den_q};
  assign done_o = done_q;
  assign quo_o  = neg_q ? (64'd0 - quo_q) : quo_q;

  // Load the operands on start, then shift, compare and subtract
  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = 65'd0;
      quo_d  = num_i[63] ? (64'd0 - num_i) : num_i;
      den_d  = den_i[63] ? (64'd0 - den_i) : den_i;
      neg_d  = num_i[63] ^ den_i[63];
      cnt_d  = 7'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[64]) begin
        rem_d = diff;
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = shl;
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 7'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

endmodule

// File: rtl/core/hpt_back.sv
// Back part: sequencer running the compensation steps over a shared
// 32x32 multiplier and the iterative divider, plus the output register.
// Depends on hpt_pkg and hpt_divider.
module hpt_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  output logic             q_take_o,
  input  hpt_pkg::sample_t q_data_i,
  input  hpt_pkg::cal_t    cal_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [14:0]      temp_o,
  output logic [23:0]      pres_o,
  output logic [16:0]      hum_o
);

  // Step codes
  localparam logic [5:0] S_IDLE = 6'd0;
  localparam logic [5:0] S_T0 = 6'd1,  S_T1 = 6'd2,  S_T2 = 6'd3,  S_T3 = 6'd4;
  localparam logic [5:0] S_T4 = 6'd5,  S_T5 = 6'd6,  S_T6 = 6'd7,  S_T7 = 6'd8;
  localparam logic [5:0] S_T8 = 6'd9,  S_T9 = 6'd10;
  localparam logic [5:0] S_P0 = 6'd11, S_P1 = 6'd12, S_P2 = 6'd13, S_P3 = 6'd14;
  localparam logic [5:0] S_P4 = 6'd15, S_P5 = 6'd16, S_P6 = 6'd17, S_P7 = 6'd18;
  localparam logic [5:0] S_P8 = 6'd19, S_P9 = 6'd20, S_P10 = 6'd21, S_P11 = 6'd22;
  localparam logic [5:0] S_P12 = 6'd23, S_P13 = 6'd24, S_P14 = 6'd25, S_P15 = 6'd26;
  localparam logic [5:0] S_P16 = 6'd27, S_P17 = 6'd28, S_P18 = 6'd29, S_P19 = 6'd30;
  localparam logic [5:0] S_P20 = 6'd31, S_P21 = 6'd32, S_P22 = 6'd33, S_P23 = 6'd34;
  localparam logic [5:0] S_P24 = 6'd35, S_P25 = 6'd36, S_P26 = 6'd37, S_P27 = 6'd38;
  localparam logic [5:0] S_H0 = 6'd39, S_H1 = 6'd40, S_H2 = 6'd41, S_H3 = 6'd42;
  localparam logic [5:0] S_H4 = 6'd43, S_H5 = 6'd44, S_H6 = 6'd45, S_H7 = 6'd46;
  localparam logic [5:0] S_H8 = 6'd47, S_H9 = 6'd48, S_H10 = 6'd49, S_H11 = 6'd50;
  localparam logic [5:0] S_H12 = 6'd51, S_H13 = 6'd52, S_H14 = 6'd53, S_H15 = 6'd54;
  localparam logic [5:0] S_H16 = 6'd55, S_H17 = 6'd56, S_H18 = 6'd57;

  // Operation kinds
  localparam logic [1:0] K_ALU = 2'd0, K_MUL = 2'd1, K_DIV = 2'd2;

  // Destinations
  localparam logic [3:0] D_NONE = 4'd0, D_A = 4'd1, D_B = 4'd2, D_C = 4'd3, D_D = 4'd4;
  localparam logic [3:0] D_E = 4'd5, D_F = 4'd6, D_TF = 4'd7, D_TEMP = 4'd8;
  localparam logic [3:0] D_PRES = 4'd9, D_HUM = 4'd10;

  logic [5:0]  step_q, step_d;
  logic [63:0] va_q, vb_q, vc_q, vd_q, ve_q, vf_q, tf_q;
  logic [14:0] temp_q;
  logic [23:0] pres_q;
  logic [19:0] adc_t_q, adc_p_q;
  logic [15:0] adc_h_q;
  logic        out_valid_q;
  logic [14:0] out_temp_q;
  logic [23:0] out_pres_q;
  logic [16:0] out_hum_q;

  logic [1:0]  kind;
  logic [3:0]  dst;
  logic [63:0] opx, opy, alu_r, wr_val;
  logic        advance, wr_en;

  logic [1:0]  mcnt_q;
  logic [63:0] acc_q;
  logic [31:0] m_x, m_y;
  logic [63:0] prod;

  logic        div_start_q, div_done;
  logic [63:0] div_quo;

  logic [63:0] adc_t_z, adc_p_z, adc_h_z, tmp, tmp2;
  logic [31:0] pu;
  logic        out_free;

  assign adc_t_z  = {44'd0, adc_t_q};
  assign adc_p_z  = {44'd0, adc_p_q};
  assign adc_h_z  = {48'd0, adc_h_q};
  assign out_free = ~out_valid_q | ~out_stall_i;
  assign q_take_o = (step_q == S_IDLE) & q_valid_i;

  // Decode the current step
  always_comb begin
    kind   = K_ALU;
    dst    = D_NONE;
    opx    = 64'd0;
    opy    = 64'd0;
    alu_r  = 64'd0;
    tmp    = 64'd0;
    tmp2   = 64'd0;
    pu     = 32'd0;
    step_d = step_q + 6'd1;
    case (step_q)
      S_IDLE: step_d = q_valid_i ? S_T0 : S_IDLE;
      // temperature, 32-bit wrap
      S_T0: begin
        dst = D_A;
        alu_r = hpt_pkg::w32((adc_t_z >> 3) - ({48'd0, cal_i.t1} << 1));
      end
      S_T1: begin kind = K_MUL; dst = D_A; opx = va_q; opy = 64'(cal_i.t2); end
      S_T2: begin dst = D_A; alu_r = hpt_pkg::sdiv_p2(hpt_pkg::w32(va_q), 11); end
      S_T3: begin dst = D_B; alu_r = hpt_pkg::w32((adc_t_z >> 4) - {48'd0, cal_i.t1}); end
      S_T4: begin kind = K_MUL; dst = D_B; opx = vb_q; opy = vb_q; end
      S_T5: begin dst = D_B; alu_r = hpt_pkg::sdiv_p2(hpt_pkg::w32(vb_q), 12); end
      S_T6: begin kind = K_MUL; dst = D_B; opx = vb_q; opy = 64'(cal_i.t3); end
      S_T7: begin dst = D_B; alu_r = hpt_pkg::sdiv_p2(hpt_pkg::w32(vb_q), 14); end
      S_T8: begin dst = D_TF; alu_r = hpt_pkg::w32(va_q + vb_q); end
      S_T9: begin
        dst = D_TEMP;
        tmp = hpt_pkg::sdiv_p2(hpt_pkg::w32((tf_q << 2) + tf_q + 64'd128), 8);
        if ($signed(tmp) < -64'sd4000) begin
          alu_r = -64'sd4000;
        end else if ($signed(tmp) > 64'sd8500) begin
          alu_r = 64'd8500;
        end else begin
          alu_r = tmp;
        end
      end
      // pressure, 64-bit wrap
      S_P0:  begin dst = D_A; alu_r = tf_q - 64'd128000; end
      S_P1:  begin kind = K_MUL; dst = D_B; opx = va_q; opy = va_q; end
      S_P2:  begin kind = K_MUL; dst = D_C; opx = vb_q; opy = 64'(cal_i.p6); end
      S_P3:  begin kind = K_MUL; dst = D_D; opx = va_q; opy = 64'(cal_i.p5); end
      S_P4:  begin dst = D_C; alu_r = vc_q + (vd_q << 17); end
      S_P5:  begin dst = D_C; alu_r = vc_q + (64'(cal_i.p4) << 35); end
      S_P6:  begin kind = K_MUL; dst = D_D; opx = vb_q; opy = 64'(cal_i.p3); end
      S_P7:  begin dst = D_D; alu_r = hpt_pkg::sdiv_p2(vd_q, 8); end
      S_P8:  begin kind = K_MUL; dst = D_E; opx = va_q; opy = 64'(cal_i.p2); end
      S_P9:  begin dst = D_D; alu_r = vd_q + (ve_q << 12); end
      S_P10: begin dst = D_D; alu_r = vd_q + (64'd1 << 47); end
      S_P11: begin kind = K_MUL; dst = D_D; opx = vd_q; opy = {48'd0, cal_i.p1}; end
      S_P12: begin dst = D_A; alu_r = hpt_pkg::sdiv_p2(vd_q, 33); end
      // zero divisor: take the minimum and go straight to humidity
      S_P13: begin
        if (va_q == 64'd0) begin
          dst    = D_PRES;
          alu_r  = 64'd3000000;
          step_d = S_H0;
        end
      end
      S_P14: begin dst = D_D; alu_r = ((64'd1048576 - adc_p_z) << 31) - vc_q; end
      S_P15: begin kind = K_MUL; dst = D_D; opx = vd_q; opy = 64'd3125; end
      S_P16: begin kind = K_DIV; dst = D_D; opx = vd_q; opy = va_q; end
      S_P17: begin dst = D_E; alu_r = hpt_pkg::sdiv_p2(vd_q, 13); end
      S_P18: begin kind = K_MUL; dst = D_B; opx = ve_q; opy = ve_q; end
      S_P19: begin kind = K_MUL; dst = D_B; opx = vb_q; opy = 64'(cal_i.p9); end
      S_P20: begin dst = D_B; alu_r = hpt_pkg::sdiv_p2(vb_q, 25); end
      S_P21: begin kind = K_MUL; dst = D_E; opx = vd_q; opy = 64'(cal_i.p8); end
      S_P22: begin dst = D_E; alu_r = hpt_pkg::sdiv_p2(ve_q, 19); end
      S_P23: begin dst = D_D; alu_r = vd_q + vb_q + ve_q; end
      S_P24: begin dst = D_D; alu_r = hpt_pkg::sdiv_p2(vd_q, 8) + (64'(cal_i.p7) << 4); end
      S_P25: begin dst = D_D; alu_r = hpt_pkg::sdiv_p2(vd_q, 1); end
      S_P26: begin kind = K_MUL; dst = D_D; opx = vd_q; opy = 64'd100; end
      S_P27: begin
        dst  = D_PRES;
        tmp  = hpt_pkg::sdiv_p2(vd_q, 7);
        pu   = tmp[31:0];
        if (pu < 32'd3000000) begin
          alu_r = 64'd3000000;
        end else if (pu > 32'd11000000) begin
          alu_r = 64'd11000000;
        end else begin
          alu_r = {32'd0, pu};
        end
      end
      // humidity, 32-bit wrap
      S_H0: begin dst = D_A; alu_r = hpt_pkg::w32(tf_q - 64'd76800); end
      S_H1: begin kind = K_MUL; dst = D_D; opx = 64'(cal_i.h5); opy = va_q; end
      S_H2: begin
        dst = D_E;
        tmp = hpt_pkg::w32((adc_h_z << 14) - (64'(cal_i.h4) << 20) - vd_q + 64'd16384);
        alu_r = hpt_pkg::sdiv_p2(tmp, 15);
      end
      S_H3:  begin kind = K_MUL; dst = D_B; opx = va_q; opy = 64'(cal_i.h6); end
      S_H4:  begin dst = D_B; alu_r = hpt_pkg::sdiv_p2(hpt_pkg::w32(vb_q), 10); end
      S_H5:  begin kind = K_MUL; dst = D_C; opx = va_q; opy = {56'd0, cal_i.h3}; end
      S_H6:  begin
        dst = D_C;
        alu_r = hpt_pkg::w32(hpt_pkg::sdiv_p2(hpt_pkg::w32(vc_q), 11) + 64'd32768);
      end
      S_H7:  begin kind = K_MUL; dst = D_D; opx = vb_q; opy = vc_q; end
      S_H8:  begin
        dst = D_D;
        alu_r = hpt_pkg::w32(hpt_pkg::sdiv_p2(hpt_pkg::w32(vd_q), 10) + 64'd2097152);
      end
      S_H9:  begin kind = K_MUL; dst = D_B; opx = vd_q; opy = 64'(cal_i.h2); end
      S_H10: begin dst = D_B; alu_r = hpt_pkg::sdiv_p2(hpt_pkg::w32(vb_q + 64'd8192), 14); end
      S_H11: begin kind = K_MUL; dst = D_C; opx = ve_q; opy = vb_q; end
      S_H12: begin dst = D_C; alu_r = hpt_pkg::w32(vc_q); end
      S_H13: begin dst = D_F; alu_r = hpt_pkg::sdiv_p2(vc_q, 15); end
      S_H14: begin kind = K_MUL; dst = D_D; opx = vf_q; opy = vf_q; end
      S_H15: begin dst = D_D; alu_r = hpt_pkg::sdiv_p2(hpt_pkg::w32(vd_q), 7); end
      S_H16: begin kind = K_MUL; dst = D_D; opx = vd_q; opy = {56'd0, cal_i.h1}; end
      S_H17: begin
        dst = D_E;
        alu_r = hpt_pkg::w32(vc_q - hpt_pkg::sdiv_p2(hpt_pkg::w32(vd_q), 4));
      end
      S_H18: begin
        dst    = D_HUM;
        step_d = S_IDLE;
        tmp2   = ve_q;
        if (tmp2[63]) begin
          tmp2 = 64'd0;
        end else if (tmp2 > 64'd419430400) begin
          tmp2 = 64'd419430400;
        end
        alu_r = tmp2 >> 12;
      end
      default: step_d = S_IDLE;
    endcase
  end

  // Shared multiplier: low 64 bits from three 32x32 partial products
  assign m_x  = (mcnt_q == 2'd2) ? opx[63:32] : opx[31:0];
  assign m_y  = (mcnt_q == 2'd1) ? opy[63:32] : opy[31:0];
  assign prod = {32'd0, m_x} * {32'd0, m_y};

  // Decide when the step retires and what it writes
  always_comb begin
    advance = 1'b0;
    wr_val  = alu_r;
    case (kind)
      K_ALU: advance = (step_q != S_H18) | out_free;
      K_MUL: begin
        advance = (mcnt_q == 2'd3);
        wr_val  = acc_q;
      end
      K_DIV: begin
        advance = div_done;
        wr_val  = div_quo;
      end
      default: advance = 1'b0;
    endcase
    wr_en = advance & (step_q != S_IDLE);
  end

  hpt_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start_q),
    .num_i  (vd_q),
    .den_i  (va_q),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= S_IDLE;
      mcnt_q      <= 2'd0;
      div_start_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (step_q == S_IDLE) begin
        step_q <= step_d;
      end else if (advance) begin
        step_q <= step_d;
      end
      mcnt_q      <= (kind == K_MUL && step_q != S_IDLE) ? mcnt_q + 2'd1 : 2'd0;
      // fire the divider on entry to its step
      div_start_q <= (step_q == S_P15) & advance;
      if (wr_en && dst == D_HUM) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (q_take_o) begin
      adc_t_q <= q_data_i.raw_t;
      adc_p_q <= q_data_i.raw_p;
      adc_h_q <= q_data_i.raw_h;
    end
    if (kind == K_MUL) begin
      if (mcnt_q == 2'd0) begin
        acc_q <= prod;
      end else begin
        acc_q <= acc_q + {prod[31:0], 32'd0};
      end
    end
    if (wr_en) begin
      case (dst)
        D_A:    va_q <= wr_val;
        D_B:    vb_q <= wr_val;
        D_C:    vc_q <= wr_val;
        D_D:    vd_q <= wr_val;
        D_E:    ve_q <= wr_val;
        D_F:    vf_q <= wr_val;
        D_TF:   tf_q <= wr_val;
        D_TEMP: temp_q <= wr_val[14:0];
        D_PRES: pres_q <= wr_val[23:0];
        D_HUM: begin
          out_temp_q <= temp_q;
          out_pres_q <= pres_q;
          out_hum_q  <= wr_val[16:0];
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign temp_o      = out_temp_q;
  assign pres_o      = out_pres_q;
  assign hum_o       = out_hum_q;

endmodule

// File: rtl/core/humidity_pressure_temp_compensation_core.sv
// Top level of the temperature, pressure and humidity compensation core.
// Depends on hpt_pkg, hpt_front and hpt_back (with hpt_divider inside).
//
// One raw sample gives one beat holding the compensated temperature (0.01 C),
// pressure (0.01 Pa) and humidity (1/1024 %RH). Samples enter a two-beat
// queue; a sequencer then runs them one at a time over a shared 32x32
// multiplier and a one-bit-per-cycle 64-bit divider for the pressure
// quotient. A sample uses 22 multiplications and one division (17 and
// no division when the pressure divisor is zero, which skips the
// divider step). The output register holds a finished result while the
// next sample is worked on. Calibration is to be written through the
// plain write port while the core idles; the core itself does not
// enforce this.
module humidity_pressure_temp_compensation_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [19:0] raw_temperature_i,
  input  logic [19:0] raw_pressure_i,
  input  logic [15:0] raw_humidity_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [14:0] temperature_centi_o,
  output logic [23:0] pressure_centipascal_o,
  output logic [16:0] humidity_q10_o
);

  logic [63:0] cal0_q, cal1_q, cal2_q;
  logic [7:0]  cal3_q;
  logic [55:0] cal4_q;
  hpt_pkg::cal_t    cal;
  hpt_pkg::sample_t in_data, q_data;
  logic             q_valid, q_take;
  logic [14:0]      temp;

  // Hold calibration bytes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal0_q <= 64'd0;
      cal1_q <= 64'd0;
      cal2_q <= 64'd0;
      cal3_q <= 8'd0;
      cal4_q <= 56'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hpt_pkg::CfgBytes0To7:   cal0_q <= cfg_wdata_i;
        hpt_pkg::CfgBytes8To15:  cal1_q <= cfg_wdata_i;
        hpt_pkg::CfgBytes16To23: cal2_q <= cfg_wdata_i;
        hpt_pkg::CfgHumFirst:    cal3_q <= cfg_wdata_i[7:0];
        hpt_pkg::CfgBytes26To32: cal4_q <= cfg_wdata_i[55:0];
        default: ;
      endcase
    end
  end

  assign cal = hpt_pkg::unpack_cal(cal0_q, cal1_q, cal2_q, cal3_q, cal4_q);

  assign in_data.raw_t = raw_temperature_i;
  assign in_data.raw_p = raw_pressure_i;
  assign in_data.raw_h = raw_humidity_i;

  hpt_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i (in_data),
    .q_valid_o (q_valid),
    .q_take_i  (q_take),
    .q_data_o  (q_data)
  );

  hpt_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_take_o   (q_take),
    .q_data_i   (q_data),
    .cal_i      (cal),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .temp_o     (temp),
    .pres_o     (pressure_centipascal_o),
    .hum_o      (humidity_q10_o)
  );

  assign temperature_centi_o = signed'(temp);

endmodule

// File: rtl/core/hpt_checker.sv
// Port-level checker for the compensation core, bound to the top level.
// Depends only on the top level's ports.
module hpt_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [14:0] temperature_centi_o,
  input logic [23:0]        pressure_centipascal_o,
  input logic [16:0]        humidity_q10_o
);

  // A stalled result beat stays
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // A stalled result does not change
  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(pressure_centipascal_o) &&
      $stable(temperature_centi_o) && $stable(humidity_q10_o))
    else $error("stalled result changed");

  // Temperature inside its clamp
  a_temp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> temperature_centi_o >= -15'sd4000 && temperature_centi_o <= 15'sd8500)
    else $error("temperature out of range");

  // Pressure inside its clamp
  a_pres: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pressure_centipascal_o >= 24'd3000000 &&
      pressure_centipascal_o <= 24'd11000000)
    else $error("pressure out of range");

  // Humidity inside its clamp
  a_hum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> humidity_q10_o <= 17'd102400)
    else $error("humidity out of range");

endmodule

bind humidity_pressure_temp_compensation_core hpt_checker u_hpt_checker (
  .clk_i                 (clk_i),
  .rst_ni                (rst_ni),
  .out_valid_o           (out_valid_o),
  .out_stall_i           (out_stall_i),
  .temperature_centi_o   (temperature_centi_o),
  .pressure_centipascal_o(pressure_centipascal_o),
  .humidity_q10_o        (humidity_q10_o)
);
